### src/hbx_pkg.sv
// ----------------------------------------------------------------------------
// hbx_pkg
// Shared widths, stop table, pipeline types and register indexes for the
// elevation colormap pipeline.
// ----------------------------------------------------------------------------
package hbx_pkg;

   localparam int ZW          = 32;                 // elevation width, Q24.8
   localparam int COLOR_STOPS = 11;
   localparam int SEGS        = COLOR_STOPS - 1;
   localparam int QB          = $clog2(SEGS + 1);   // segment index bits
   localparam int TW          = ZW + QB;            // scaled position width
   localparam int CW          = 8;                  // color channel width
   localparam int SIW         = 4;                  // stop table index width
   localparam int PW          = ZW + CW;            // offset * step product
   localparam int NW          = ZW + CW + 2;        // rounding numerator
   localparam int CSR_IW      = 2;

   localparam logic [CSR_IW-1:0] CSR_Z_LOW   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_Z_HIGH  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_MISSING = 2'd2;

   localparam logic [ZW-1:0] Z_LOW_RESET   = 32'd0;
   localparam logic [ZW-1:0] Z_HIGH_RESET  = 32'd256000;
   localparam logic [ZW-1:0] MISSING_RESET = 32'h8000_0000;

   // eleven stops, padded with white
   localparam logic [CW-1:0] STOP_TABLE [16][3] = '{
      '{8'd37,  8'd57,  8'd175}, '{8'd40,  8'd127, 8'd251},
      '{8'd50,  8'd190, 8'd255}, '{8'd106, 8'd235, 8'd255},
      '{8'd138, 8'd236, 8'd174}, '{8'd205, 8'd255, 8'd162},
      '{8'd240, 8'd236, 8'd121}, '{8'd255, 8'd189, 8'd87},
      '{8'd255, 8'd161, 8'd68},  '{8'd255, 8'd186, 8'd133},
      '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}
   };

   typedef enum logic [1:0] {
      MODE_INTERP,
      MODE_BLACK,
      MODE_FIRST,
      MODE_LAST
   } mode_type;

   typedef struct packed {
      mode_type        mode;
      logic            frame_end;
      logic [ZW-1:0]   d;          // ramp span, z_high - z_low
   } side_type;

   typedef struct packed {
      logic            frame_end;
      logic            is_missing;
      logic [CW-1:0]   blue;
      logic [CW-1:0]   green;
      logic [CW-1:0]   red;
   } pixel_type;

endpackage

### src/hbx_front.sv
// ----------------------------------------------------------------------------
// hbx_front
// Two stages: classify the sample against the ramp, then flag samples above it
// and scale the offset by the segment count.
// ----------------------------------------------------------------------------
module hbx_front import hbx_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [ZW-1:0]   elevation,
   input  logic            frame_end,
   input  logic [ZW-1:0]   z_low,
   input  logic [ZW-1:0]   z_high,
   input  logic [ZW-1:0]   missing_marker,
   output logic            out_valid,
   output side_type        out_side,
   output logic [TW-1:0]   out_t
);

   logic [ZW:0]    span;
   logic [ZW:0]    offset;
   side_type       a_side_in;
   logic           a_valid_ff;
   side_type       a_side_ff;
   logic [ZW-1:0]  a_u_ff;
   side_type       b_side_in;
   logic [TW-1:0]  b_t_in;
   logic           b_valid_ff;
   side_type       b_side_ff;
   logic [TW-1:0]  b_t_ff;

   assign span   = {z_high[ZW-1], z_high} - {z_low[ZW-1], z_low};
   assign offset = {elevation[ZW-1], elevation} - {z_low[ZW-1], z_low};

   always_comb begin
      a_side_in.frame_end = frame_end;
      a_side_in.d         = span[ZW-1:0];
      priority if (elevation == missing_marker) begin
         a_side_in.mode = MODE_BLACK;
      end else if (offset[ZW] || offset == '0 || span[ZW] || span == '0) begin
         a_side_in.mode = MODE_FIRST;
      end else begin
         a_side_in.mode = MODE_INTERP;
      end
   end

   always_comb begin
      b_side_in = a_side_ff;
      if (a_side_ff.mode == MODE_INTERP && a_u_ff > a_side_ff.d) begin
         b_side_in.mode = MODE_LAST;
      end
      // t - 1, so the segment select lands a sample on an inner end in the
      // lower segment with offset equal to the span
      b_t_in = TW'(a_u_ff) * TW'(SEGS) - TW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff <= a_side_in;
         a_u_ff    <= offset[ZW-1:0];
         b_side_ff <= b_side_in;
         b_t_ff    <= b_t_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_side  = b_side_ff;
   assign out_t     = b_t_ff;

endmodule

### src/hbx_segdiv.sv
// ----------------------------------------------------------------------------
// hbx_segdiv
// Restoring divider, one quotient bit per stage: segment index and offset
// within the segment from the scaled position and the ramp span.
// ----------------------------------------------------------------------------
module hbx_segdiv import hbx_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  side_type        in_side,
   input  logic [TW-1:0]   in_t,
   output logic            out_valid,
   output side_type        out_side,
   output logic [QB-1:0]   out_k,
   output logic [ZW-1:0]   out_rem
);

   logic            valid_ff [QB];
   side_type        side_ff  [QB];
   logic [TW-1:0]   rem_ff   [QB];
   logic [QB-1:0]   q_ff     [QB];

   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int J = QB - 1 - s;

      logic            prev_valid;
      side_type        prev_side;
      logic [TW-1:0]   prev_rem;
      logic [QB-1:0]   prev_q;
      logic [TW-1:0]   divisor;
      logic [TW-1:0]   rem_in;
      logic [QB-1:0]   q_in;

      if (s == 0) begin : g_head
         assign prev_valid = in_valid;
         assign prev_side  = in_side;
         assign prev_rem   = in_t;
         assign prev_q     = '0;
      end else begin : g_tail
         assign prev_valid = valid_ff[s-1];
         assign prev_side  = side_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_q     = q_ff[s-1];
      end

      assign divisor = TW'(prev_side.d) << J;

      always_comb begin
         rem_in = prev_rem;
         q_in   = prev_q;
         if (prev_rem >= divisor) begin
            rem_in  = prev_rem - divisor;
            q_in[J] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[s] <= prev_side;
            rem_ff[s]  <= rem_in;
            q_ff[s]    <= q_in;
         end
      end
   end

   // remainder is below the span, so it fits the elevation width
   assign out_valid = valid_ff[QB-1];
   assign out_side  = side_ff[QB-1];
   assign out_k     = q_ff[QB-1];
   assign out_rem   = rem_ff[QB-1][ZW-1:0];

endmodule

### src/hbx_interp.sv
// ----------------------------------------------------------------------------
// hbx_interp
// Per channel: stop lookup, offset times color step, rounding numerator,
// then a bit-per-stage divide by twice the span. Last stage output is
// combinational: lower stop plus or minus the quotient; pick the final color.
// ----------------------------------------------------------------------------
module hbx_interp import hbx_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  side_type        in_side,
   input  logic [QB-1:0]   in_k,
   input  logic [ZW-1:0]   in_rem,
   output logic            out_valid,
   output pixel_type       out_pixel
);

   // lookup stage
   logic [SIW-1:0]          idx0;
   logic [SIW-1:0]          idx1;
   logic [2:0][CW-1:0]      l_a_in;
   logic [2:0]              l_neg_in;
   logic [2:0][CW-1:0]      l_mag_in;
   logic                    l_valid_ff;
   side_type                l_side_ff;
   logic [ZW-1:0]           l_r_ff;
   logic [2:0][CW-1:0]      l_a_ff;
   logic [2:0]              l_neg_ff;
   logic [2:0][CW-1:0]      l_mag_ff;
   // multiply stage
   logic [2:0][PW-1:0]      m_p_in;
   logic                    m_valid_ff;
   side_type                m_side_ff;
   logic [2:0][CW-1:0]      m_a_ff;
   logic [2:0]              m_neg_ff;
   logic [2:0][PW-1:0]      m_p_ff;
   // numerator stage
   logic [2:0][NW-1:0]      n_num_in;
   logic                    n_valid_ff;
   side_type                n_side_ff;
   logic [2:0][CW-1:0]      n_a_ff;
   logic [2:0]              n_neg_ff;
   logic [2:0][NW-1:0]      n_num_ff;
   // divide stages
   logic                    dv_valid_ff [CW];
   side_type                dv_side_ff  [CW];
   logic [2:0][CW-1:0]      dv_a_ff     [CW];
   logic [2:0]              dv_neg_ff   [CW];
   logic [2:0][NW-1:0]      dv_rem_ff   [CW];
   logic [2:0][CW-1:0]      dv_q_ff     [CW];
   // final select
   logic [2:0][CW-1:0]      chan;
   side_type                last_side;

   assign idx0 = SIW'(in_k);
   assign idx1 = idx0 + SIW'(1);

   for (genvar c = 0; c < 3; c++) begin : g_lookup
      logic [CW-1:0] lo_stop;
      logic [CW-1:0] hi_stop;
      logic [CW:0]   step;

      assign lo_stop     = STOP_TABLE[idx0][c];
      assign hi_stop     = STOP_TABLE[idx1][c];
      assign step        = {1'b0, hi_stop} - {1'b0, lo_stop};
      assign l_a_in[c]   = lo_stop;
      assign l_neg_in[c] = step[CW];
      assign l_mag_in[c] = step[CW] ? CW'(-step) : step[CW-1:0];

      assign m_p_in[c]   = PW'(l_r_ff) * PW'(l_mag_ff[c]);

      // falling step: floor(-y) = -ceil(y), hence the minus one
      assign n_num_in[c] = NW'({m_p_ff[c], 1'b0}) + NW'(m_side_ff.d)
                           - NW'(m_neg_ff[c]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         n_valid_ff <= 1'b0;
      end else if (adv) begin
         l_valid_ff <= in_valid;
         m_valid_ff <= l_valid_ff;
         n_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l_side_ff <= in_side;
         l_r_ff    <= in_rem + ZW'(1);
         l_a_ff    <= l_a_in;
         l_neg_ff  <= l_neg_in;
         l_mag_ff  <= l_mag_in;
         m_side_ff <= l_side_ff;
         m_a_ff    <= l_a_ff;
         m_neg_ff  <= l_neg_ff;
         m_p_ff    <= m_p_in;
         n_side_ff <= m_side_ff;
         n_a_ff    <= m_a_ff;
         n_neg_ff  <= m_neg_ff;
         n_num_ff  <= n_num_in;
      end
   end

   for (genvar s = 0; s < CW; s++) begin : g_div
      localparam int J = CW - 1 - s;

      logic                 prev_valid;
      side_type             prev_side;
      logic [2:0][CW-1:0]   prev_a;
      logic [2:0]           prev_neg;
      logic [2:0][NW-1:0]   prev_rem;
      logic [2:0][CW-1:0]   prev_q;
      logic [NW-1:0]        divisor;
      logic [2:0][NW-1:0]   rem_in;
      logic [2:0][CW-1:0]   q_in;

      if (s == 0) begin : g_head
         assign prev_valid = n_valid_ff;
         assign prev_side  = n_side_ff;
         assign prev_a     = n_a_ff;
         assign prev_neg   = n_neg_ff;
         assign prev_rem   = n_num_ff;
         assign prev_q     = '0;
      end else begin : g_tail
         assign prev_valid = dv_valid_ff[s-1];
         assign prev_side  = dv_side_ff[s-1];
         assign prev_a     = dv_a_ff[s-1];
         assign prev_neg   = dv_neg_ff[s-1];
         assign prev_rem   = dv_rem_ff[s-1];
         assign prev_q     = dv_q_ff[s-1];
      end

      assign divisor = NW'({prev_side.d, 1'b0}) << J;

      always_comb begin
         rem_in = prev_rem;
         q_in   = prev_q;
         for (int c = 0; c < 3; c++) begin
            if (prev_rem[c] >= divisor) begin
               rem_in[c]  = prev_rem[c] - divisor;
               q_in[c][J] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[s] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_side_ff[s] <= prev_side;
            dv_a_ff[s]    <= prev_a;
            dv_neg_ff[s]  <= prev_neg;
            dv_rem_ff[s]  <= rem_in;
            dv_q_ff[s]    <= q_in;
         end
      end
   end

   assign last_side = dv_side_ff[CW-1];

   for (genvar c = 0; c < 3; c++) begin : g_final
      logic [CW+1:0] sum;
      logic [CW-1:0] interp;

      assign sum = dv_neg_ff[CW-1][c]
                   ? {2'b00, dv_a_ff[CW-1][c]} - {2'b00, dv_q_ff[CW-1][c]}
                   : {2'b00, dv_a_ff[CW-1][c]} + {2'b00, dv_q_ff[CW-1][c]};

      always_comb begin
         priority if (sum[CW+1]) begin
            interp = '0;
         end else if (sum[CW]) begin
            interp = '1;
         end else begin
            interp = sum[CW-1:0];
         end
      end

      always_comb begin
         unique case (last_side.mode)
            MODE_INTERP: chan[c] = interp;
            MODE_BLACK:  chan[c] = '0;
            MODE_FIRST:  chan[c] = STOP_TABLE[0][c];
            MODE_LAST:   chan[c] = STOP_TABLE[SEGS][c];
            default:     chan[c] = '0;
         endcase
      end
   end

   assign out_valid            = dv_valid_ff[CW-1];
   assign out_pixel.red        = chan[0];
   assign out_pixel.green      = chan[1];
   assign out_pixel.blue       = chan[2];
   assign out_pixel.is_missing = (last_side.mode == MODE_BLACK);
   assign out_pixel.frame_end  = last_side.frame_end;

endmodule

### src/hbx_outbuf.sv
// ----------------------------------------------------------------------------
// hbx_outbuf
// Output register plus one skid register. The pipeline advances only while
// the skid register is empty, so the advance enable comes from a flop.
// ----------------------------------------------------------------------------
module hbx_outbuf import hbx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  pixel_type   in_pixel,
   input  logic        out_ready,
   output logic        adv,
   output logic        out_valid,
   output pixel_type   out_pixel
);

   logic        out_valid_ff;
   logic        out_valid_in;
   pixel_type   out_ff;
   pixel_type   out_in;
   logic        skid_valid_ff;
   logic        skid_valid_in;
   pixel_type   skid_ff;
   pixel_type   skid_in;
   logic        take;

   assign adv  = !skid_valid_ff;
   assign take = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // pipeline is frozen; drain the skid beat into the output
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_in       = in_pixel;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = in_pixel;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_ff;

endmodule

### src/elevation_haxby_colormap.sv
// ----------------------------------------------------------------------------
// elevation_haxby_colormap
// Elevation sample to RGB pixel over eleven Haxby stops, linear between
// stops with round half up; no-data samples come out black.
//
//   channel  dir  beat contents
//   req_*    in   tdata[31:0] elevation (Q24.8), tlast frame_end
//   rsp_*    out  tdata red/green/blue, tuser is_missing, tlast frame_end_out
//   csr_*    in   csr_index register, csr_wdata value (always ready)
//
// One sample per cycle while req_tready is high. In this build there are
// QB = 4 segment-select divide stages and CW = 8 rounding divide stages.
// Synchronous reset clears every valid bit and loads register defaults.
// When a result is held, one more beat lands in the skid register and
// req_tready drops the next cycle; the whole pipeline then freezes.
// ----------------------------------------------------------------------------
module elevation_haxby_colormap import hbx_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ZW-1:0]       req_tdata,   // [31:0] elevation
   input  logic                req_tlast,   // frame_end
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [3*CW-1:0]     rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   output logic                rsp_tuser,   // [0] is_missing
   output logic                rsp_tlast,   // frame_end_out
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_IW-1:0]   csr_index,
   input  logic [ZW-1:0]       csr_wdata
);

   logic [ZW-1:0]   z_low_ff;
   logic [ZW-1:0]   z_high_ff;
   logic [ZW-1:0]   missing_ff;
   logic            adv;
   logic            fr_valid;
   side_type        fr_side;
   logic [TW-1:0]   fr_t;
   logic            sd_valid;
   side_type        sd_side;
   logic [QB-1:0]   sd_k;
   logic [ZW-1:0]   sd_rem;
   logic            ip_valid;
   pixel_type       ip_pixel;
   pixel_type       rsp_pixel;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         z_low_ff   <= Z_LOW_RESET;
         z_high_ff  <= Z_HIGH_RESET;
         missing_ff <= MISSING_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_Z_LOW:   z_low_ff   <= csr_wdata;
            CSR_Z_HIGH:  z_high_ff  <= csr_wdata;
            CSR_MISSING: missing_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = adv;

   hbx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (req_tvalid),
      .elevation      (req_tdata),
      .frame_end      (req_tlast),
      .z_low          (z_low_ff),
      .z_high         (z_high_ff),
      .missing_marker (missing_ff),
      .out_valid      (fr_valid),
      .out_side       (fr_side),
      .out_t          (fr_t)
   );

   hbx_segdiv u_segdiv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_t      (fr_t),
      .out_valid (sd_valid),
      .out_side  (sd_side),
      .out_k     (sd_k),
      .out_rem   (sd_rem)
   );

   hbx_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sd_valid),
      .in_side   (sd_side),
      .in_k      (sd_k),
      .in_rem    (sd_rem),
      .out_valid (ip_valid),
      .out_pixel (ip_pixel)
   );

   hbx_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ip_valid),
      .in_pixel  (ip_pixel),
      .out_ready (rsp_tready),
      .adv       (adv),
      .out_valid (rsp_tvalid),
      .out_pixel (rsp_pixel)
   );

   assign rsp_tdata = {rsp_pixel.blue, rsp_pixel.green, rsp_pixel.red};
   assign rsp_tuser = rsp_pixel.is_missing;
   assign rsp_tlast = rsp_pixel.frame_end;

endmodule

### src/hbx_check.sv
// ----------------------------------------------------------------------------
// hbx_check
// Port-level checks on the colormap: output hold, black on no-data,
// reset behavior and skid back-pressure.
// ----------------------------------------------------------------------------
module hbx_check (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tready,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [23:0]   rsp_tdata,
   input  logic          rsp_tuser,
   input  logic          rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_missing_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("no-data pixel is not black");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not clear output and skid");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("req_tready low without a held result");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("skid full while output register empty");

endmodule

bind elevation_haxby_colormap hbx_check u_hbx_check (.*);
